FILE: hdl/scs_pkg.sv
// Shared types, codes and sizes for the searchable control stack.
package scs_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int REF_W       = 64;
    localparam int CLS_W       = 32;
    localparam int CTX_W       = 32;
    localparam int ACT_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int ECOUNT_W    = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH             = 4'd0,
        ACT_POP              = 4'd1,
        ACT_READ             = 4'd2,
        ACT_CLEAR            = 4'd3,
        ACT_FIND_REF         = 4'd4,
        ACT_FIND_CLASS       = 4'd5,
        ACT_FIND_CLASS_CTX   = 4'd6,
        ACT_FIND_CLASS_OTHER = 4'd7,
        ACT_FIND_CTX         = 4'd8
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [REF_W-1:0] ref_value;
        logic [CLS_W-1:0] class_value;
        logic [CTX_W-1:0] context_value;
    } t_entry;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic    shift_dn;
        logic    shift_up;
        logic    clr;
        logic    cmp;
        t_action act;
        t_entry  key;
    } t_cell_cmd;

endpackage

FILE: hdl/scs_ifs.sv
// Handshake channels: request words in, response words out.
interface scs_req_if import scs_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [REF_W-1:0] ref_value;
    logic [CLS_W-1:0] class_value;
    logic [CTX_W-1:0] context_value;

    modport source (output valid, action, ref_value, class_value, context_value,
                    input ready);
    modport sink   (input valid, action, ref_value, class_value, context_value,
                    output ready);
endinterface

interface scs_rsp_if import scs_pkg::*;;
    logic                valid;
    logic                ready;
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic [REF_W-1:0]    out_ref;
    logic [CLS_W-1:0]    out_class;
    logic [CTX_W-1:0]    out_context;
    logic [ECOUNT_W-1:0] entry_count;

    modport source (output valid, hit, status, out_ref, out_class, out_context,
                    entry_count, input ready);
    modport sink   (input valid, hit, status, out_ref, out_class, out_context,
                    entry_count, output ready);
endinterface

FILE: hdl/scs_cell.sv
// One stack cell: holds an entry and its live flag, shifts with its neighbors, compares.
module scs_cell import scs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_up_entry,
    input  logic      i_up_live,
    input  t_entry    i_dn_entry,
    input  logic      i_dn_live,
    output t_entry    o_entry,
    output logic      o_live,
    output logic      o_match
);

    t_entry r_entry;
    logic   r_live;
    logic   r_match;
    logic   n_match;

    always_comb begin
        case (i_cmd.act)
            ACT_FIND_REF:         n_match = (r_entry.ref_value == i_cmd.key.ref_value);
            ACT_FIND_CLASS:       n_match = (r_entry.class_value == i_cmd.key.class_value);
            ACT_FIND_CLASS_CTX:   n_match = (r_entry.class_value == i_cmd.key.class_value) &&
                                            (r_entry.context_value == i_cmd.key.context_value);
            ACT_FIND_CLASS_OTHER: n_match = (r_entry.class_value == i_cmd.key.class_value) &&
                                            (r_entry.context_value != i_cmd.key.context_value);
            ACT_FIND_CTX:         n_match = (r_entry.context_value == i_cmd.key.context_value);
            default:              n_match = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_live <= 1'b0;
            end else if (i_cmd.shift_dn) begin
                r_live <= i_up_live;
            end else if (i_cmd.shift_up) begin
                r_live <= i_dn_live;
            end
            // Hold the match until the next compare so a stalled response keeps it
            if (i_cmd.cmp) begin
                r_match <= r_live & n_match;
            end
        end
    end

    // Payload: no reset, only live entries are ever read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_dn) begin
            r_entry <= i_up_entry;
        end else if (i_cmd.shift_up) begin
            r_entry <= i_dn_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_live  = r_live;
    assign o_match = r_match;

endmodule

FILE: hdl/searchable_control_stack.sv
// Top level: LIFO stack with associative search, built as a chain of shifting cells.
// Each request is latched, executed, then reduced and loaded into the response register.
// The block takes no new word until the control sequencer has gone from execute through done
//   back to idle; the registered per-cell match flags are OR-reduced in the cycle after the compare.
// The response register frees the output side: a held response stalls only the final step.
// Synchronous active-low reset empties the stack (count and live flags) and the response.
module searchable_control_stack import scs_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    scs_req_if.sink   i_req,
    scs_rsp_if.source o_rsp
);

    // Sequencer and latched request
    t_state  r_state, n_state;
    t_action r_act;
    t_entry  r_key;
    logic [CNT_W-1:0] r_count;

    // Pending result built in the execute step
    logic    r_hit;
    logic    r_srch;
    t_status r_status;
    t_entry  r_res;
    logic    n_hit;
    logic    n_srch;
    t_status n_status;
    t_entry  n_res;

    // Response register
    logic                r_out_valid;
    logic                r_out_hit;
    t_status             r_out_status;
    t_entry              r_out_entry;
    logic [ECOUNT_W-1:0] r_out_count;

    // Decoded controls
    logic      w_in_ready;
    logic      w_accept;
    logic      w_exec;
    logic      w_load;
    logic      w_not_full;
    logic      w_not_empty;
    t_cell_cmd w_cmd;

    // Chain wiring
    t_entry                 w_entry [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] w_live;
    logic [STACK_DEPTH-1:0] w_match;

    assign w_accept    = i_req.valid & w_in_ready;
    assign w_not_full  = (r_count < CNT_W'(STACK_DEPTH));
    assign w_not_empty = (r_count != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs and cell command decode
    always_comb begin
        w_in_ready   = 1'b0;
        w_exec       = 1'b0;
        w_load       = 1'b0;
        w_cmd        = '0;
        w_cmd.act    = r_act;
        w_cmd.key    = r_key;
        case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
            end
            S_EXEC: begin
                w_exec = 1'b1;
                case (r_act)
                    ACT_PUSH:             w_cmd.shift_dn = w_not_full;
                    ACT_POP:              w_cmd.shift_up = w_not_empty;
                    ACT_CLEAR:            w_cmd.clr      = 1'b1;
                    ACT_FIND_REF,
                    ACT_FIND_CLASS,
                    ACT_FIND_CLASS_CTX,
                    ACT_FIND_CLASS_OTHER,
                    ACT_FIND_CTX:         w_cmd.cmp      = 1'b1;
                    default:              w_cmd.cmp      = 1'b0;
                endcase
            end
            S_DONE: begin
                w_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    assign i_req.ready = w_in_ready;

    // Chain of cells: cell 0 is the top of the stack, a push shifts everything down.
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_entry w_up_entry, w_dn_entry;
        logic   w_up_live, w_dn_live;

        if (g == 0) begin : g_top
            assign w_up_entry = r_key;
            assign w_up_live  = 1'b1;
        end else begin : g_mid_up
            assign w_up_entry = w_entry[g-1];
            assign w_up_live  = w_live[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_bottom
            assign w_dn_entry = '0;
            assign w_dn_live  = 1'b0;
        end else begin : g_mid_dn
            assign w_dn_entry = w_entry[g+1];
            assign w_dn_live  = w_live[g+1];
        end

        scs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_up_entry (w_up_entry),
            .i_up_live  (w_up_live),
            .i_dn_entry (w_dn_entry),
            .i_dn_live  (w_dn_live),
            .o_entry    (w_entry[g]),
            .o_live     (w_live[g]),
            .o_match    (w_match[g])
        );
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Update the count as the cells shift
            if (w_exec) begin
                case (r_act)
                    ACT_PUSH:  if (w_not_full)  r_count <= r_count + CNT_W'(1);
                    ACT_POP:   if (w_not_empty) r_count <= r_count - CNT_W'(1);
                    ACT_CLEAR: r_count <= '0;
                    default:   r_count <= r_count;
                endcase
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result of the execute step, from the latched action and the current count
    always_comb begin
        n_hit    = 1'b0;
        n_srch   = 1'b0;
        n_status = ST_OK;
        n_res    = '0;
        case (r_act)
            ACT_PUSH: begin
                if (w_not_full) n_hit    = 1'b1;
                else            n_status = ST_FULL;
            end
            ACT_POP, ACT_READ: begin
                if (w_not_empty) begin
                    n_hit = 1'b1;
                    n_res = w_entry[0];
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            ACT_CLEAR: begin
                n_hit = 1'b1;
            end
            ACT_FIND_REF, ACT_FIND_CLASS, ACT_FIND_CLASS_CTX,
            ACT_FIND_CLASS_OTHER, ACT_FIND_CTX: begin
                n_srch = 1'b1;
            end
            default: begin
                n_hit = 1'b0;
            end
        endcase
    end

    // Request latch, pending result and response payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= t_action'(i_req.action);
            r_key <= '{ref_value:     i_req.ref_value,
                       class_value:   i_req.class_value,
                       context_value: i_req.context_value};
        end
        if (w_exec) begin
            r_hit    <= n_hit;
            r_srch   <= n_srch;
            r_status <= n_status;
            r_res    <= n_res;
        end
        if (w_load) begin
            // Searches take their hit from the registered cell matches
            r_out_hit    <= r_srch ? (|w_match) : r_hit;
            r_out_status <= r_status;
            r_out_entry  <= r_res;
            r_out_count  <= ECOUNT_W'(r_count);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.out_ref     = r_out_entry.ref_value;
    assign o_rsp.out_class   = r_out_entry.class_value;
    assign o_rsp.out_context = r_out_entry.context_value;
    assign o_rsp.entry_count = r_out_count;

endmodule

FILE: bench/tb.sv
// Self-checking bench for the searchable control stack: random words, prediction, scoreboard.
`timescale 1ns / 1ps

module tb;
    import scs_pkg::*;

    localparam int N_WORDS         = 1350;
    localparam int RSP_HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES    = 12;
    localparam int MAX_REPORTS     = 30;

    // Action codes outside the defined set; the block must leave the stack alone.
    localparam logic [ACT_W-1:0] ACT_UNDEF_LO = 4'd9;
    localparam logic [ACT_W-1:0] ACT_UNDEF_HI = 4'd15;

    typedef struct {
        logic [ACT_W-1:0] act;
        t_entry           key;
    } t_stack_cmd;

    typedef struct {
        logic                hit;
        logic [STATUS_W-1:0] status;
        t_entry              entry;
        logic [ECOUNT_W-1:0] entry_count;
    } t_stack_reply;

    // Shadow stack: predict each reply at accept, then match replies in order.
    class stack_scoreboard;
        t_entry       slots[STACK_DEPTH];
        int unsigned  depth;
        t_stack_reply replies_due[$];
        int unsigned  errors, checked, peak;
        int unsigned  n_push, n_pop, n_search, n_search_hit, n_full, n_empty;

        function bit search_live(t_stack_cmd c);
            for (int i = 0; i < depth; i++) begin
                case (c.act)
                    ACT_FIND_REF:
                        if (slots[i].ref_value == c.key.ref_value) return 1'b1;
                    ACT_FIND_CLASS:
                        if (slots[i].class_value == c.key.class_value) return 1'b1;
                    ACT_FIND_CLASS_CTX:
                        if (slots[i].class_value == c.key.class_value &&
                            slots[i].context_value == c.key.context_value) return 1'b1;
                    ACT_FIND_CLASS_OTHER:
                        if (slots[i].class_value == c.key.class_value &&
                            slots[i].context_value != c.key.context_value) return 1'b1;
                    ACT_FIND_CTX:
                        if (slots[i].context_value == c.key.context_value) return 1'b1;
                    default: ;
                endcase
            end
            return 1'b0;
        endfunction

        function void apply_command(t_stack_cmd c);
            t_stack_reply r;
            r.hit    = 1'b0;
            r.status = ST_OK;
            r.entry  = '0;
            case (c.act)
                ACT_PUSH: begin
                    n_push++;
                    if (depth >= STACK_DEPTH) begin
                        r.status = ST_FULL;
                        n_full++;
                    end else begin
                        slots[depth] = c.key;
                        depth++;
                        r.hit = 1'b1;
                    end
                end
                ACT_POP, ACT_READ: begin
                    n_pop += (c.act == ACT_POP);
                    if (depth == 0) begin
                        r.status = ST_EMPTY;
                        n_empty++;
                    end else begin
                        r.entry = slots[depth-1];
                        if (c.act == ACT_POP) depth--;
                        r.hit = 1'b1;
                    end
                end
                ACT_CLEAR: begin
                    depth = 0;
                    r.hit = 1'b1;
                end
                ACT_FIND_REF, ACT_FIND_CLASS, ACT_FIND_CLASS_CTX,
                ACT_FIND_CLASS_OTHER, ACT_FIND_CTX: begin
                    r.hit = search_live(c);
                    n_search++;
                    n_search_hit += r.hit;
                end
                default: ;
            endcase
            if (depth > peak) peak = depth;
            r.entry_count = ECOUNT_W'(depth);
            replies_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [REF_W-1:0] want,
                                    logic [REF_W-1:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch: expected %0h, actual %0h",
                             $time, name, want, got);
            end
        endfunction

        function void check_reply(t_stack_reply got);
            t_stack_reply want;
            if (replies_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected reply: expected none, actual hit %0b status %0d",
                             $time, got.hit, got.status);
                return;
            end
            want = replies_due.pop_front();
            checked++;
            compare_field("hit", want.hit, got.hit);
            compare_field("status", want.status, got.status);
            compare_field("out_ref", want.entry.ref_value, got.entry.ref_value);
            compare_field("out_class", want.entry.class_value, got.entry.class_value);
            compare_field("out_context", want.entry.context_value, got.entry.context_value);
            compare_field("entry_count", want.entry_count, got.entry_count);
        endfunction

        function t_entry pick_live();
            return slots[$urandom_range(0, depth - 1)];
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    scs_req_if req_ch ();
    scs_rsp_if rsp_ch ();

    searchable_control_stack i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stack_scoreboard sb = new;

    bit offering;       // valid is high, as far as this side has driven it
    bit hold_rsp_req;   // ask the receiver for a long hold-off
    bit rsp_holding;    // receiver is inside that hold-off
    int words_sent;
    int burst_left;

    // Note every accepted request word; values seen here are the pre-edge ones.
    always @(posedge clk) begin
        if (rst_n && req_ch.valid && req_ch.ready)
            sb.apply_command('{act: req_ch.action,
                               key: '{req_ch.ref_value, req_ch.class_value,
                                      req_ch.context_value}});
    end

    // Check every accepted response word against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_reply('{hit: rsp_ch.hit, status: rsp_ch.status,
                             entry: '{rsp_ch.out_ref, rsp_ch.out_class,
                                      rsp_ch.out_context},
                             entry_count: rsp_ch.entry_count});
    end

    // Receiver: segments of steady, random, sparse and patterned ready, plus the
    // long hold-off on request, counted here in cycles.
    initial begin : rsp_sink
        int          seg_len;
        int          style;
        logic [7:0]  pattern;
        rsp_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_rsp_req) begin
                hold_rsp_req = 1'b0;
                rsp_holding  = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge clk);
                rsp_holding = 1'b0;
            end else begin
                style   = $urandom_range(0, 3);
                seg_len = $urandom_range(8, 48);
                pattern = 8'b1101_0010;
                repeat (seg_len) begin
                    case (style)
                        0: rsp_ch.ready <= 1'b1;
                        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                        2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: begin
                            rsp_ch.ready <= pattern[0];
                            pattern = {pattern[0], pattern[7:1]};
                        end
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    function automatic logic [REF_W-1:0] pick_ref();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return {32'($urandom_range(0, 3)), 32'($urandom_range(0, 7))};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [CLS_W-1:0] pick_code();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return 32'($urandom_range(0, 5));
            default:    return $urandom();
        endcase
    endfunction

    // Build one random word; searches often borrow keys from a live entry so
    // that hits and near misses both occur.
    function automatic t_stack_cmd random_cmd(int push_pct);
        t_stack_cmd c;
        t_entry     live;
        int         roll;
        c.key = '{pick_ref(), pick_code(), pick_code()};
        roll  = $urandom_range(0, 99);
        if (roll < push_pct) begin
            c.act = ACT_PUSH;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 35)      c.act = ACT_POP;
            else if (roll < 45) c.act = ACT_READ;
            else if (roll < 47) c.act = ACT_CLEAR;
            else if (roll < 49) c.act = ACT_W'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
            else begin
                c.act = ACT_W'($urandom_range(ACT_FIND_REF, ACT_FIND_CTX));
                if ($urandom_range(0, 1) && sb.depth > 0) begin
                    live = sb.pick_live();
                    c.key.ref_value   = live.ref_value;
                    c.key.class_value = live.class_value;
                    if ($urandom_range(0, 1)) c.key.context_value = live.context_value;
                end
            end
        end
        return c;
    endfunction

    function automatic t_stack_cmd make_cmd(logic [ACT_W-1:0] act, logic [REF_W-1:0] r,
                                            logic [CLS_W-1:0] c, logic [CTX_W-1:0] x);
        t_stack_cmd m;
        m.act = act;
        m.key = '{r, c, x};
        return m;
    endfunction

    // Offer one word and hold it until accepted; call in the step of a rising edge.
    task automatic send_word(t_stack_cmd c);
        req_ch.valid         <= 1'b1;
        req_ch.action        <= c.act;
        req_ch.ref_value     <= c.key.ref_value;
        req_ch.class_value   <= c.key.class_value;
        req_ch.context_value <= c.key.context_value;
        offering = 1'b1;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic drive_idle();
        if (offering) begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Send in bursts; between bursts drop valid for a random gap, unless the gap drawn is zero.
    task automatic issue(t_stack_cmd c);
        int gap;
        send_word(c);
        words_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
            if (gap > 0) begin
                drive_idle();
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Pause the sender until every predicted reply has come back.
    task automatic wait_drained();
        drive_idle();
        do @(posedge clk); while (sb.replies_due.size() != 0);
    endtask

    // Hold off the receiver and keep offering words back to back, so the
    // block fills and stalls its input.
    task automatic run_backpressure();
        drive_idle();
        hold_rsp_req = 1'b1;
        do @(posedge clk); while (!rsp_holding);
        repeat (24) begin
            send_word(random_cmd(60));
            words_sent++;
        end
    endtask

    task automatic run_directed();
        // Empty stack: refused pop and read, search misses, undefined action.
        issue(make_cmd(ACT_POP, '0, '0, '0));
        issue(make_cmd(ACT_READ, '1, '1, '1));
        issue(make_cmd(ACT_FIND_REF, '0, '0, '0));
        issue(make_cmd(ACT_FIND_CTX, '0, '0, '0));
        issue(make_cmd(ACT_UNDEF_LO, '1, '1, '1));
        // Field extremes on the stack.
        issue(make_cmd(ACT_PUSH, '1, '1, '1));
        issue(make_cmd(ACT_PUSH, '0, '0, '0));
        issue(make_cmd(ACT_PUSH, 64'h8000_0000_0000_0001, 32'h1, 32'hFFFF_FFFF));
        issue(make_cmd(ACT_READ, '0, '0, '0));
        // Each search kind hits; all but the context search also miss.
        issue(make_cmd(ACT_FIND_REF, '1, '0, '0));
        issue(make_cmd(ACT_FIND_REF, 64'h5, '0, '0));
        issue(make_cmd(ACT_FIND_CLASS, '0, 32'h1, '0));
        issue(make_cmd(ACT_FIND_CLASS, '0, 32'h7, '0));
        issue(make_cmd(ACT_FIND_CLASS_CTX, '0, 32'h1, 32'hFFFF_FFFF));
        issue(make_cmd(ACT_FIND_CLASS_CTX, '0, 32'h1, 32'h0));
        issue(make_cmd(ACT_FIND_CLASS_OTHER, '0, 32'h1, 32'h0));
        issue(make_cmd(ACT_FIND_CLASS_OTHER, '0, 32'h0, 32'h0));
        issue(make_cmd(ACT_FIND_CTX, '0, '0, 32'hFFFF_FFFF));
        issue(make_cmd(ACT_UNDEF_HI, '0, '0, '0));
        // Pop, clear, then confirm the stack reads empty.
        issue(make_cmd(ACT_POP, '0, '0, '0));
        issue(make_cmd(ACT_CLEAR, '0, '0, '0));
        issue(make_cmd(ACT_POP, '0, '0, '0));
        issue(make_cmd(ACT_FIND_CLASS, '0, 32'h1, '0));
    endtask

    initial begin : stimulus
        int  push_pct;
        int  seg_len;
        bit  second_stress;
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.action        <= '0;
        req_ch.ref_value     <= '0;
        req_ch.class_value   <= '0;
        req_ch.context_value <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drained();
        run_backpressure();

        while (words_sent < N_WORDS) begin
            if (!second_stress && words_sent > N_WORDS / 2) begin
                run_backpressure();
                second_stress = 1'b1;
            end
            case ($urandom_range(0, 11))
                0: begin
                    // Fill to the top, then knock on the full stack.
                    while (sb.depth < STACK_DEPTH) issue(random_cmd(100));
                    repeat ($urandom_range(1, 3)) issue(random_cmd(100));
                end
                1: begin
                    // Drain to the bottom, then pop and read past it.
                    while (sb.depth > 0) issue(make_cmd(ACT_POP, '0, '0, '0));
                    issue(make_cmd(ACT_POP, '0, '0, '0));
                    issue(make_cmd(ACT_READ, '0, '0, '0));
                end
                2: wait_drained();
                default: begin
                    push_pct = ($urandom_range(0, 2) == 0) ? 25 : $urandom_range(40, 75);
                    seg_len  = $urandom_range(10, 40);
                    repeat (seg_len) issue(random_cmd(push_pct));
                end
            endcase
        end

        // Let the last replies arrive, then leave room for any stray one.
        drive_idle();
        do @(posedge clk); while (sb.replies_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d words, %0d pushes, %0d pops, %0d searches with %0d hits",
                 words_sent, sb.n_push, sb.n_pop, sb.n_search, sb.n_search_hit);
        $display("summary: peak depth %0d, %0d full refusals, %0d empty refusals, %0d replies",
                 sb.peak, sb.n_full, sb.n_empty, sb.checked);
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Stop a hung run.
    initial begin : watchdog
        #(5_000_000);
        $display("tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/scs_pkg.sv
hdl/scs_ifs.sv
hdl/scs_cell.sv
hdl/searchable_control_stack.sv
bench/tb.sv
